// File: rtl/assert_macros.svh
// Assertion macros, included by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/owtr_pkg.sv
// Package for the one-wire temperature reader: phase codes, constants, shared types.
// No dependencies.
package owtr_pkg;
    localparam int RESET_LOW_US       = 480;
    localparam int PRESENCE_SAMPLE_US = 80;
    localparam int SLOT_US            = 60;
    localparam int AVERAGE_WRAP       = 101;
    localparam int RESET_TAIL_US      = 400;
    localparam int WRITE_LOW_US       = 50;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_SP  = 8'hBE;

    localparam logic [1:0] REG_CAL  = 2'd0;
    localparam logic [1:0] REG_CONV = 2'd1;
    localparam logic [1:0] REG_GAP  = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0, PH_R1_LOW = 5'd1, PH_R1_WAIT = 5'd2, PH_R1_TAIL = 5'd3,
        PH_GAP1 = 5'd4, PH_W_SKIP1 = 5'd5, PH_W_CONV = 5'd6, PH_CONV_WAIT = 5'd7,
        PH_R2_LOW = 5'd8, PH_R2_WAIT = 5'd9, PH_R2_TAIL = 5'd10, PH_GAP2 = 5'd11,
        PH_W_SKIP2 = 5'd12, PH_W_READ = 5'd13, PH_READ = 5'd14
    } phase_t;

    // Top-level controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IN   = 4'b0001,
        ST_MATH = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } ctl_state_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        presence_seen;
        logic        done_res;
        logic [11:0] temperature_16ths;
        logic [21:0] calibrated_16ths;
        logic [29:0] average_4096ths;
    } result_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic bus_step;   // run one microsecond of the bus sequencer
        logic math_start; // begin the measurement arithmetic
        logic load_out;   // capture the result item
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic finished;   // the last bus step completed a measurement
        logic math_done;  // arithmetic finished
    } dp_stat_t;
endpackage

// File: rtl/owtr_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a type parameter.
interface owtr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/owtr_div.sv
// Sequential signed divider: restoring, one quotient bit per cycle.
// Depends on owtr_pkg.
module owtr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [46:0] dividend,  // signed
    input  logic [7:0]  divisor,   // unsigned, nonzero
    output logic        done,
    output logic [46:0] quotient   // signed, truncated toward zero
);
    import owtr_pkg::*;

    logic [46:0] q_reg, q_next;
    logic [7:0]  r_reg, r_next;
    logic [7:0]  d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;
    logic [46:0] mag;

    // Magnitude of the dividend and one shift-subtract step.
    always_comb
    begin
        mag = dividend[46] ? (47'd0 - dividend) : dividend;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        run_next = run_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[46]} - {1'b0, d_reg};
        if (start)
        begin
            q_next = mag;
            r_next = 8'd0;
            d_next = divisor;
            cnt_next = 6'd0;
            neg_next = dividend[46];
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[8])
            begin
                r_next = trial[7:0];
                q_next = {q_reg[45:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[6:0], q_reg[46]};
                q_next = {q_reg[45:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd46)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? (47'd0 - q_reg) : q_reg;
endmodule

// File: rtl/owtr_datapath.sv
// Datapath: bus sequencer state, decode, calibration and averaging arithmetic.
// Depends on owtr_pkg and owtr_div.
module owtr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  owtr_pkg::dp_cmd_t   cmd_i,
    output owtr_pkg::dp_stat_t  stat_o,
    input  logic                in_cmd,
    input  logic                in_line,
    input  logic [15:0]         cal_pct,
    input  logic [19:0]         conv_wait,
    input  logic [15:0]         gap_us,
    output owtr_pkg::result_t   result
);
    import owtr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [19:0] us_reg, us_next;
    logic [2:0]  bit_reg, bit_next;
    logic        byte_reg, byte_next;
    logic [15:0] word_reg, word_next;
    logic        pres_reg, pres_next;
    logic [6:0]  n_reg, n_next;
    logic [29:0] avg_reg, avg_next;
    logic [11:0] temp_reg, temp_next;
    logic [21:0] calv_reg, calv_next;
    logic        drive_reg, drive_next;
    logic        fin_reg, fin_next;
    result_t     res_reg;

    phase_t      ph;
    logic [19:0] len;
    logic [19:0] us_inc;
    logic [7:0]  cbyte;
    phase_t      adv;

    // Arithmetic pipeline registers.
    logic [1:0]  mstep_reg;
    logic [11:0] t_reg;
    logic [28:0] prod_reg;      // t * cal, signed
    logic [21:0] c_reg;
    logic [46:0] num_reg;
    logic        div_start_reg;
    logic [15:0] cal_eff;
    logic [28:0] prod;
    logic [21:0] c_val;
    logic [28:0] pmag;
    logic [57:0] cprod;
    logic [21:0] cmag;
    logic [37:0] avg_n;
    logic [46:0] num;
    logic [46:0] quo;
    logic        div_done;
    logic        div_start;
    logic [11:0] t_val;

    function automatic logic [19:0] plen(phase_t p, logic [19:0] cw, logic [15:0] g);
        case (p)
            PH_R1_LOW, PH_R2_LOW:   plen = 20'(RESET_LOW_US);
            PH_R1_WAIT, PH_R2_WAIT: plen = 20'(PRESENCE_SAMPLE_US);
            PH_R1_TAIL, PH_R2_TAIL: plen = 20'(RESET_TAIL_US);
            PH_GAP1, PH_GAP2:       plen = {4'd0, g};
            PH_CONV_WAIT:           plen = cw;
            PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_READ: plen = 20'(WRITE_LOW_US + 1);
            PH_READ:                plen = 20'(2 + SLOT_US);
            default:                plen = 20'd1;
        endcase
    endfunction

    // Next phase, skipping waits of zero length.
    always_comb
    begin
        case (phase_reg)
            PH_R1_TAIL: adv = (gap_us == 16'd0) ? PH_W_SKIP1 : PH_GAP1;
            PH_W_CONV:  adv = (conv_wait == 20'd0) ? PH_R2_LOW : PH_CONV_WAIT;
            PH_R2_TAIL: adv = (gap_us == 16'd0) ? PH_W_SKIP2 : PH_GAP2;
            default:    adv = phase_t'(phase_reg + 5'd1);
        endcase
    end

    // One microsecond of the bus sequence.
    always_comb
    begin
        phase_next = phase_reg;
        us_next = us_reg;
        bit_next = bit_reg;
        byte_next = byte_reg;
        word_next = word_reg;
        pres_next = pres_reg;
        drive_next = drive_reg;
        fin_next = fin_reg;
        ph = phase_reg;
        len = 20'd1;
        us_inc = 20'd0;
        cbyte = CMD_SKIP_ROM;
        if (cmd_i.bus_step)
        begin
            fin_next = 1'b0;
            drive_next = 1'b0;
            us_next = us_reg;
            if (phase_reg == PH_IDLE && in_cmd)
            begin
                phase_next = PH_R1_LOW;
                us_next = 20'd0;
                bit_next = 3'd0;
                byte_next = 1'b0;
                word_next = 16'd0;
            end
            ph = (phase_reg == PH_IDLE && in_cmd) ? PH_R1_LOW : phase_reg;
            len = plen(ph, conv_wait, gap_us);
            cbyte = (ph == PH_W_CONV) ? CMD_CONVERT :
                    (ph == PH_W_READ) ? CMD_READ_SP : CMD_SKIP_ROM;
            if (ph != PH_IDLE)
            begin
                case (ph)
                    PH_R1_LOW, PH_R2_LOW: drive_next = 1'b1;
                    PH_R1_WAIT, PH_R2_WAIT:
                    begin
                        if (us_next + 20'd1 >= len)
                            pres_next = !in_line;
                    end
                    PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_READ:
                    begin
                        if (cbyte[bit_next])
                            drive_next = (us_next == 20'd0);
                        else
                            drive_next = (us_next < 20'(WRITE_LOW_US));
                    end
                    PH_READ:
                    begin
                        drive_next = (us_next < 20'd2);
                        if (us_next == 20'd2 && in_line)
                            word_next[{byte_reg, bit_reg}] = 1'b1;
                    end
                    default: ;
                endcase
                us_inc = us_next + 20'd1;
                us_next = us_inc;
                if (us_inc >= len)
                begin
                    us_next = 20'd0;
                    case (ph)
                        PH_W_SKIP1, PH_W_CONV, PH_W_SKIP2, PH_W_READ:
                        begin
                            bit_next = bit_next + 3'd1;
                            if (bit_next == 3'd0)
                                phase_next = adv;
                        end
                        PH_READ:
                        begin
                            bit_next = bit_reg + 3'd1;
                            if (bit_reg == 3'd7)
                            begin
                                byte_next = !byte_reg;
                                if (byte_reg)
                                begin
                                    phase_next = PH_IDLE;
                                    fin_next = 1'b1;
                                end
                            end
                        end
                        default: phase_next = (ph == PH_R1_LOW && phase_reg == PH_IDLE) ?
                                              PH_R1_WAIT : adv;
                    endcase
                end
            end
        end
    end

    // Measurement arithmetic: decode, scale, then average through the divider.
    // The division by 100 is a multiplication by ceil(2^35 / 100), exact for
    // magnitudes below 2^30.
    assign t_val = (word_reg == 16'hFFFF) ? 12'd0 : {word_reg[15], word_reg[10:0]};
    assign cal_eff = (cal_pct == 16'd0) ? 16'd100 : cal_pct;
    assign prod = $signed({{17{t_reg[11]}}, t_reg}) * $signed({13'd0, cal_eff});
    assign pmag = prod_reg[28] ? (29'd0 - prod_reg) : prod_reg;
    assign cprod = {29'd0, pmag} * 58'd343597384;
    assign cmag = cprod[56:35];
    assign c_val = prod_reg[28] ? (22'd0 - cmag) : cmag;
    assign avg_n = $signed({{8{avg_reg[29]}}, avg_reg}) * $signed({31'd0, n_reg});
    assign num = {{9{avg_n[37]}}, avg_n} + {{17{c_reg[21]}}, c_reg, 8'd0};
    assign div_start = div_start_reg;

    owtr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  ({1'b0, n_reg} + 8'd1),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        avg_next = avg_reg;
        n_next = n_reg;
        temp_next = temp_reg;
        calv_next = calv_reg;
        if (div_done)
        begin
            avg_next = quo[29:0];
            n_next = (n_reg >= 7'(AVERAGE_WRAP)) ? 7'd1 : n_reg + 7'd1;
            temp_next = t_reg;
            calv_next = c_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            us_reg <= 20'd0;
            bit_reg <= 3'd0;
            byte_reg <= 1'b0;
            word_reg <= 16'd0;
            pres_reg <= 1'b0;
            n_reg <= 7'd0;
            avg_reg <= 30'd0;
            temp_reg <= 12'd0;
            calv_reg <= 22'd0;
            drive_reg <= 1'b0;
            fin_reg <= 1'b0;
            mstep_reg <= 2'd0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            us_reg <= us_next;
            bit_reg <= bit_next;
            byte_reg <= byte_next;
            word_reg <= word_next;
            pres_reg <= pres_next;
            n_reg <= n_next;
            avg_reg <= avg_next;
            temp_reg <= temp_next;
            calv_reg <= calv_next;
            drive_reg <= drive_next;
            fin_reg <= fin_next;
            div_start_reg <= (mstep_reg == 2'd3);
            if (cmd_i.math_start)
                mstep_reg <= 2'd1;
            else if (mstep_reg != 2'd0)
                mstep_reg <= mstep_reg + 2'd1;
        end
    end

    // Arithmetic stage registers: the product, the scaled value, then the
    // numerator of the average, one per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd_i.math_start)
            t_reg <= t_val;
        if (mstep_reg == 2'd1)
            prod_reg <= prod;
        if (mstep_reg == 2'd2)
            c_reg <= c_val;
        if (mstep_reg == 2'd3)
            num_reg <= num;
        if (cmd_i.load_out)
        begin
            res_reg.drive_low <= drive_reg;
            res_reg.busy_res <= (phase_reg != PH_IDLE);
            res_reg.presence_seen <= pres_reg;
            res_reg.done_res <= fin_reg;
            res_reg.temperature_16ths <= temp_reg;
            res_reg.calibrated_16ths <= calv_reg;
            res_reg.average_4096ths <= avg_reg;
        end
    end

    assign stat_o.finished = fin_reg;
    assign stat_o.math_done = div_done;
    assign result = res_reg;
endmodule

// File: rtl/owtr_ctrl.sv
// Controller: sequences input acceptance, arithmetic and result delivery.
// Depends on owtr_pkg.
module owtr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  owtr_pkg::dp_stat_t  stat_i,
    output owtr_pkg::dp_cmd_t   cmd_o
);
    import owtr_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    assign in_ready = (state_reg == ST_IN) && !ovalid_reg;
    assign out_valid = ovalid_reg;

    // Step the bus on an accepted item, run the arithmetic when a measurement
    // ends, then load the result item.
    always_comb
    begin
        state_next = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd_o = '0;
        case (state_reg)
            ST_IN:
            begin
                if (in_valid && !ovalid_reg)
                begin
                    cmd_o.bus_step = 1'b1;
                    state_next = ST_MATH;
                end
            end
            ST_MATH:
            begin
                if (stat_i.finished)
                begin
                    cmd_o.math_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (stat_i.math_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd_o.load_out = 1'b1;
                ovalid_next = 1'b1;
                state_next = ST_IN;
            end
            default: state_next = ST_IN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IN;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

// File: rtl/one_wire_temp_sensor_reader_unit.sv
// Top level of the one-wire temperature reader.
// Depends on owtr_pkg, owtr_if, owtr_ctrl, owtr_datapath, assert_macros.svh.
//
// Usage: each input item is one microsecond tick (cmd = 0) or a start request
// with a tick (cmd = 1), together with the sampled bus level. Every input item
// yields exactly one result item: the bus drive for that microsecond, busy,
// presence, done and the stored temperature, calibrated value and average.
// Path: a plain tick goes through the math and output states to the output
// register; the tick that completes a measurement also goes through three
// arithmetic stages and the 47-step serial divider of the averaging. The next
// item is taken the cycle after the result has left the output register, so
// one item is in flight at a time. Configuration writes go in through cfg_we /
// cfg_index / cfg_data; the user writes only while idle, unchecked by the block.
// Reset clears the sequencer, the average and the stored values, and loads the
// register defaults (100 percent, 800000 us conversion, 1000 us gap).
// If the receiver stalls, the result holds in the output register and no new
// item is accepted until it is taken.
module one_wire_temp_sensor_reader_unit (
    input  logic        clk,
    input  logic        rst_n,
    owtr_if.sink        in_ch,
    owtr_if.source      out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import owtr_pkg::*;
    `include "assert_macros.svh"

    logic [15:0] cal_reg;
    logic [19:0] conv_reg;
    logic [15:0] gap_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    result_t     res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= 16'd100;
            conv_reg <= 20'd800000;
            gap_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAL:  cal_reg <= cfg_data[15:0];
                REG_CONV: conv_reg <= cfg_data;
                REG_GAP:  gap_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    owtr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat_i    (stat),
        .cmd_o     (cmd)
    );

    owtr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_i     (cmd),
        .stat_o    (stat),
        .in_cmd    (in_ch.data[1]),
        .in_line   (in_ch.data[0]),
        .cal_pct   (cal_reg),
        .conv_wait (conv_reg),
        .gap_us    (gap_reg),
        .result    (res)
    );

    assign out_ch.data = res;

    // An accepted item starts exactly one bus step and no arithmetic at once.
    `ASSERT_IMPL(a_step_once, cmd.bus_step, !cmd.math_start && !cmd.load_out)
    // No input is taken while a result waits.
    `ASSERT_IMPL(a_no_accept_when_full, out_ch.valid, !in_ch.ready)
    // The done flag is only shown on a result that ended the sequence.
    `ASSERT_IMPL(a_done_idle, out_ch.valid && out_ch.data.done_res,
                 !out_ch.data.busy_res)
endmodule
